// ===== hw/rtl/knn_tk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_tk_pkg
// Shared widths, opcodes and cell control type for the top-k sorted list.
// ----------------------------------------------------------------------------
package knn_tk_pkg;

    // List depth and field widths
    localparam int MAX_K    = 16;
    localparam int DIST_W   = 32;
    localparam int INDEX_W  = 24;
    localparam int POS_W    = 4;
    localparam int OP_W     = 2;
    localparam int CNT_W    = $clog2(MAX_K + 1);
    localparam int SEL_W    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CALLS_W  = 32;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Item opcodes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Per-cell control from the list controller
    typedef struct packed {
        logic clr;   // restore reset contents
        logic upd;   // insert beat acts on this cell
        logic tail;  // cell lies at or past the insertion limit
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/knn_tk_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_tk_cell
// One entry of the sorted list: holds a (distance, point) pair, compares it
// against the candidate and either keeps it, takes the candidate or takes the
// pair of its left neighbour.
// ----------------------------------------------------------------------------
module knn_tk_cell
    import knn_tk_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_ctrl_t         ctrl,
    input  logic [DIST_W-1:0]  cand_dist,
    input  logic [INDEX_W-1:0] cand_point,
    input  logic [DIST_W-1:0]  left_dist,
    input  logic [INDEX_W-1:0] left_point,
    input  logic               left_gt,
    output logic [DIST_W-1:0]  cell_dist,
    output logic [INDEX_W-1:0] cell_point,
    output logic               cell_gt,
    output logic               cell_lt
);

    logic [DIST_W-1:0]  dist_reg;
    logic [INDEX_W-1:0] point_reg;
    logic [DIST_W-1:0]  dist_next;
    logic [INDEX_W-1:0] point_next;

    // Compare held distance with the candidate
    assign cell_gt = (dist_reg > cand_dist) || ctrl.tail;
    assign cell_lt = dist_reg < cand_dist;

    // Keep, take candidate, or take the left neighbour's pair
    always_comb begin
        dist_next  = dist_reg;
        point_next = point_reg;
        if (ctrl.upd && cell_gt) begin
            if (left_gt) begin
                dist_next  = left_dist;
                point_next = left_point;
            end else begin
                dist_next  = cand_dist;
                point_next = cand_point;
            end
        end
    end

    // Hold entry
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clr) begin
            dist_reg  <= DIST_MAX;
            point_reg <= '0;
        end else begin
            dist_reg  <= dist_next;
            point_reg <= point_next;
        end
    end

    assign cell_dist  = dist_reg;
    assign cell_point = point_reg;

endmodule

// ===== hw/rtl/knn_top_k_sorted_insert_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_top_k_sorted_insert_core
// Top-k nearest list kept in ascending distance order by a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per beat: tuser is the opcode (insert, read,
//   clear), tdata holds distance, point index and read position. m_axis
//   returns exactly one result beat per command with the insert flag, fill
//   count, full flag, worst distance, read data and the comparison count.
//   cfg_wr_en/cfg_wr_data write k_in_use (0 acts as 1, above 16 as 16) and
//   empty the list; write only while no command is in flight.
// Timing:
//   An insert updates the cells below k (a clear empties every cell) at the
//   accepting edge: those cells compare and shift in parallel. Its result is
//   formed from the updated cells while the command is held as pending and
//   is registered into the output register once that is free. Sustained
//   rate is one command per cycle while m_axis is not stalled.
// Reset and stall:
//   Reset sets every entry to maximum distance, point 0, count zero and k to
//   16 at once; no clearing pass. While m_axis is stalled one more command
//   is taken and held as pending, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module knn_top_k_sorted_insert_core
    import knn_tk_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    // Configuration: k_in_use
    input  logic          cfg_wr_en,
    input  logic [4:0]    cfg_wr_data,
    // Command stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [63:0]   s_axis_tdata,   // distance[31:0], point_index[55:32],
                                          // read_position[59:56], zero[63:60]
    input  logic [OP_W-1:0] s_axis_tuser, // opcode[1:0]
    // Result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata    // inserted[0], fill_count[5:1],
                                          // is_full[6], worst_distance[38:7],
                                          // read_distance[70:39],
                                          // read_index[94:71],
                                          // comparisons[126:95], zero[127]
);

    // Unpack command beat
    logic [DIST_W-1:0]  in_dist;
    logic [INDEX_W-1:0] in_point;
    logic [POS_W-1:0]   in_pos;
    op_t                in_op;

    assign in_dist  = s_axis_tdata[DIST_W-1:0];
    assign in_point = s_axis_tdata[DIST_W+INDEX_W-1:DIST_W];
    assign in_pos   = s_axis_tdata[DIST_W+INDEX_W+POS_W-1:DIST_W+INDEX_W];
    assign in_op    = op_t'(s_axis_tuser);

    // Control registers
    logic [4:0]         k_reg;
    logic [CNT_W-1:0]   held_reg;
    logic [CNT_W-1:0]   held_next;
    logic [CALLS_W-1:0] calls_reg;
    logic [CALLS_W-1:0] calls_next;

    // Pending command and output register
    logic               pend_reg;
    op_t                pend_op_reg;
    logic [POS_W-1:0]   pend_pos_reg;
    logic               pend_ins_reg;
    logic               m_valid_reg;
    logic [127:0]       m_data_reg;
    logic [127:0]       m_data_next;

    logic               out_free;
    logic               accept;
    logic               clr_list;
    logic               is_full;
    logic               reject;
    logic               insert_ok;
    logic [CNT_W-1:0]   eff_k;
    logic [CNT_W-1:0]   last_pos;

    // Cell row
    logic [DIST_W-1:0]  cell_dist  [MAX_K];
    logic [INDEX_W-1:0] cell_point [MAX_K];
    logic [MAX_K-1:0]   cell_gt;
    logic [MAX_K-1:0]   cell_lt;
    logic [MAX_K-1:0]   last_hit;
    cell_ctrl_t         cell_ctrl  [MAX_K];

    // Clamp k to the built depth
    always_comb begin
        if (k_reg == 5'd0) begin
            eff_k = CNT_W'(1);
        end else if (CNT_W'(k_reg) > CNT_W'(MAX_K)) begin
            eff_k = CNT_W'(MAX_K);
        end else begin
            eff_k = CNT_W'(k_reg);
        end
    end

    assign last_pos = eff_k - CNT_W'(1);
    assign is_full  = held_reg == eff_k;

    // Handshake: take a beat unless the pending slot stays blocked
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !pend_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign clr_list      = cfg_wr_en || (accept && in_op == OP_CLEAR);

    // Reject a candidate beyond the current worst (held by cell k-1)
    assign reject    = |(last_hit & cell_lt);
    assign insert_ok = accept && in_op == OP_INSERT && !reject && !cfg_wr_en;

    genvar j;
    generate
        for (j = 0; j < MAX_K; j++) begin : g_cell
            assign last_hit[j]      = CNT_W'(j) == last_pos;
            assign cell_ctrl[j].clr = clr_list;
            assign cell_ctrl[j].upd = insert_ok && (CNT_W'(j) < eff_k);
            assign cell_ctrl[j].tail = is_full ? (CNT_W'(j) == last_pos)
                                               : (CNT_W'(j) >= held_reg);
            if (j == 0) begin : g_head
                knn_tk_cell u_cell (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .ctrl       (cell_ctrl[j]),
                    .cand_dist  (in_dist),
                    .cand_point (in_point),
                    .left_dist  (in_dist),
                    .left_point (in_point),
                    .left_gt    (1'b0),
                    .cell_dist  (cell_dist[j]),
                    .cell_point (cell_point[j]),
                    .cell_gt    (cell_gt[j]),
                    .cell_lt    (cell_lt[j])
                );
            end else begin : g_body
                knn_tk_cell u_cell (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .ctrl       (cell_ctrl[j]),
                    .cand_dist  (in_dist),
                    .cand_point (in_point),
                    .left_dist  (cell_dist[j-1]),
                    .left_point (cell_point[j-1]),
                    .left_gt    (cell_gt[j-1]),
                    .cell_dist  (cell_dist[j]),
                    .cell_point (cell_point[j]),
                    .cell_gt    (cell_gt[j]),
                    .cell_lt    (cell_lt[j])
                );
            end
        end
    endgenerate

    // Advance fill count and comparison counter
    always_comb begin
        held_next  = held_reg;
        calls_next = calls_reg;
        if (clr_list) begin
            held_next  = '0;
            calls_next = '0;
        end else if (accept && in_op == OP_INSERT) begin
            calls_next = calls_reg + CALLS_W'(1);
            if (insert_ok && !is_full) begin
                held_next = held_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg     <= 5'(MAX_K);
            held_reg  <= '0;
            calls_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                k_reg <= cfg_wr_data;
            end
            held_reg  <= held_next;
            calls_reg <= calls_next;
        end
    end

    // Form the result beat from the updated list
    always_comb begin
        logic [DIST_W-1:0]  rd_dist;
        logic [INDEX_W-1:0] rd_point;
        rd_dist  = '0;
        rd_point = '0;
        if (pend_op_reg == OP_READ) begin
            if (CNT_W'(pend_pos_reg) < CNT_W'(MAX_K)) begin
                rd_dist  = cell_dist[pend_pos_reg[SEL_W-1:0]];
                rd_point = cell_point[pend_pos_reg[SEL_W-1:0]];
            end else begin
                rd_dist  = DIST_MAX;
                rd_point = '0;
            end
        end
        m_data_next = {1'b0, calls_reg, rd_point, rd_dist,
                       cell_dist[last_pos[SEL_W-1:0]], is_full, held_reg,
                       pend_ins_reg};
    end

    // Hold pending command and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                pend_reg <= 1'b1;
            end else if (out_free) begin
                pend_reg <= 1'b0;
            end
            if (out_free) begin
                m_valid_reg <= pend_reg;
            end
        end
        if (accept) begin
            pend_op_reg  <= in_op;
            pend_pos_reg <= in_pos;
            pend_ins_reg <= insert_ok;
        end
        if (out_free && pend_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_held_within_k : assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= eff_k)
        else $error("fill count exceeds k");

    a_cfg_clears : assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> (held_reg == '0) && (calls_reg == '0))
        else $error("config write did not clear the list");

    a_reject_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_op == OP_INSERT && reject && !cfg_wr_en)
            |=> $stable(held_reg))
        else $error("rejected insert changed the fill count");

    a_pend_moves : assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && out_free && !accept) |=> (m_valid_reg && !pend_reg))
        else $error("pending result not moved to output");
`endif

endmodule
